[hdl/acmv_pkg.sv]
`timescale 1ns / 1ps

package acmv_pkg;

   localparam int NUM_DIRECTIONS = 4;

   localparam int VAL_W = 32;
   localparam int ACC_W = 40;
   localparam int FRAC_W = 24;
   localparam int PROD_W = 2 * VAL_W;
   localparam int VEC_LEN = 3;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 200;

   localparam logic [1:0] LAST_INDEX = 2'd2;
   localparam logic [1:0] INDEX_LIMIT = 2'd3;

   typedef enum logic {
      ACT_LOAD_SOURCE = 1'b0,
      ACT_ELEMENT     = 1'b1
   } action_type;

   // Request held in the input register
   typedef struct packed {
      action_type              action;
      logic [1:0]              direction;
      logic [1:0]              row;
      logic [1:0]              col;
      logic signed [VAL_W-1:0] value_re;
      logic signed [VAL_W-1:0] value_im;
   } item_type;

   // Truncated products of one matrix element, ready to accumulate
   typedef struct packed {
      logic                    close;
      logic [1:0]              direction;
      logic [1:0]              col;
      logic signed [ACC_W-1:0] rr;
      logic signed [ACC_W-1:0] ii;
      logic signed [ACC_W-1:0] ri;
      logic signed [ACC_W-1:0] ir;
   } prod_type;

   function automatic logic signed [VAL_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc);
      logic upper_same;
      logic signed [VAL_W-1:0] result;
      upper_same = (acc[ACC_W-1:VAL_W-1] == '0) || (acc[ACC_W-1:VAL_W-1] == '1);
      if (upper_same) begin
         result = acc[VAL_W-1:0];
      end else if (acc[ACC_W-1]) begin
         result = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(VAL_W-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

[hdl/adjoint_complex_3x3_matvec.sv]
`timescale 1ns / 1ps

// A closing element (row 2, col 2) reaches rsp_tvalid via input and product regs.
// Throughput: one request per cycle unless stalled; four 32x32 multipliers work
// on each element. The pipeline stalls only when a closing element reaches the
// output register while the previous result still waits on rsp_tready.
// Reset (synchronous, active high) clears the source vector, the accumulators
// and all valid flags.
module adjoint_complex_3x3_matvec
   import acmv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // direction[1:0], row[3:2], col[5:4], value_re[37:6], value_im[69:38], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // action[0]
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // out_direction[1:0], res0_re[33:2], res0_im[65:34], res1_re[97:66],
   // res1_im[129:98], res2_re[161:130], res2_im[193:162], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic                    advance;
   logic                    rsp_free;

   logic                    s0_valid_ff, s0_valid_in;
   item_type                s0_ff, s0_in;

   logic                    s1_valid_ff, s1_valid_in;
   prod_type                s1_ff, s1_in;

   logic signed [VAL_W-1:0] src_re_ff [VEC_LEN];
   logic signed [VAL_W-1:0] src_im_ff [VEC_LEN];
   logic signed [VAL_W-1:0] src_re_in [VEC_LEN];
   logic signed [VAL_W-1:0] src_im_in [VEC_LEN];

   logic signed [ACC_W-1:0] acc_re_ff [VEC_LEN];
   logic signed [ACC_W-1:0] acc_im_ff [VEC_LEN];
   logic signed [ACC_W-1:0] acc_re_in [VEC_LEN];
   logic signed [ACC_W-1:0] acc_im_in [VEC_LEN];

   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic                    elem_ok;
   logic signed [VAL_W-1:0] src_re_sel, src_im_sel;
   logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;

   logic signed [ACC_W-1:0] sum_re [VEC_LEN];
   logic signed [ACC_W-1:0] sum_im [VEC_LEN];
   logic signed [VAL_W-1:0] res_re [VEC_LEN];
   logic signed [VAL_W-1:0] res_im [VEC_LEN];

   // Hold the pipeline only when a closing element meets a result still waiting
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign advance    = rsp_free || !(s1_valid_ff && s1_ff.close);
   assign req_tready = advance;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Input register
   always_comb begin
      s0_valid_in     = req_tvalid;
      s0_in.action    = action_type'(req_tuser);
      s0_in.direction = req_tdata[1:0];
      s0_in.row       = req_tdata[3:2];
      s0_in.col       = req_tdata[5:4];
      s0_in.value_re  = req_tdata[37:6];
      s0_in.value_im  = req_tdata[69:38];
   end

   // Source load and multiply
   always_comb begin
      elem_ok = (s0_ff.action == ACT_ELEMENT) && (s0_ff.row < INDEX_LIMIT)
                && (s0_ff.col < INDEX_LIMIT) && (int'(s0_ff.direction) < NUM_DIRECTIONS);

      src_re_sel = src_re_ff[0];
      src_im_sel = src_im_ff[0];
      for (int i = 0; i < VEC_LEN; i++) begin
         if (s0_ff.row == 2'(i)) begin
            src_re_sel = src_re_ff[i];
            src_im_sel = src_im_ff[i];
         end
         if (s0_valid_ff && (s0_ff.action == ACT_LOAD_SOURCE) && (s0_ff.row == 2'(i))) begin
            src_re_in[i] = s0_ff.value_re;
            src_im_in[i] = s0_ff.value_im;
         end else begin
            src_re_in[i] = src_re_ff[i];
            src_im_in[i] = src_im_ff[i];
         end
      end

      p_rr = s0_ff.value_re * src_re_sel;
      p_ii = s0_ff.value_im * src_im_sel;
      p_ri = s0_ff.value_re * src_im_sel;
      p_ir = s0_ff.value_im * src_re_sel;

      // Dropping the low fraction bits floors the product
      s1_valid_in     = s0_valid_ff && elem_ok;
      s1_in.close     = (s0_ff.row == LAST_INDEX) && (s0_ff.col == LAST_INDEX);
      s1_in.direction = s0_ff.direction;
      s1_in.col       = s0_ff.col;
      s1_in.rr        = p_rr[PROD_W-1:FRAC_W];
      s1_in.ii        = p_ii[PROD_W-1:FRAC_W];
      s1_in.ri        = p_ri[PROD_W-1:FRAC_W];
      s1_in.ir        = p_ir[PROD_W-1:FRAC_W];
   end

   // Accumulate and emit
   always_comb begin
      for (int i = 0; i < VEC_LEN; i++) begin
         if (s1_ff.col == 2'(i)) begin
            sum_re[i] = acc_re_ff[i] + s1_ff.rr + s1_ff.ii;
            sum_im[i] = acc_im_ff[i] + s1_ff.ri - s1_ff.ir;
         end else begin
            sum_re[i] = acc_re_ff[i];
            sum_im[i] = acc_im_ff[i];
         end
         res_re[i] = sat_acc(sum_re[i]);
         res_im[i] = sat_acc(sum_im[i]);
         if (s1_valid_ff && s1_ff.close) begin
            acc_re_in[i] = '0;
            acc_im_in[i] = '0;
         end else if (s1_valid_ff) begin
            acc_re_in[i] = sum_re[i];
            acc_im_in[i] = sum_im[i];
         end else begin
            acc_re_in[i] = acc_re_ff[i];
            acc_im_in[i] = acc_im_ff[i];
         end
      end

      rsp_tvalid_in = s1_valid_ff && s1_ff.close;
      rsp_tdata_in  = {6'b0, res_im[2], res_re[2], res_im[1], res_re[1],
                       res_im[0], res_re[0], s1_ff.direction};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < VEC_LEN; i++) begin
            src_re_ff[i] <= '0;
            src_im_ff[i] <= '0;
            acc_re_ff[i] <= '0;
            acc_im_ff[i] <= '0;
         end
      end else begin
         if (advance) begin
            s0_valid_ff <= s0_valid_in;
            s1_valid_ff <= s1_valid_in;
            for (int i = 0; i < VEC_LEN; i++) begin
               src_re_ff[i] <= src_re_in[i];
               src_im_ff[i] <= src_im_in[i];
               acc_re_ff[i] <= acc_re_in[i];
               acc_im_ff[i] <= acc_im_in[i];
            end
         end
         if (rsp_free) begin
            rsp_tvalid_ff <= rsp_tvalid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
      end
      if (rsp_free && rsp_tvalid_in) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_result_from_close : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(s1_valid_ff && s1_ff.close))
      else $error("result raised without a closing element");

   a_clear_after_close : assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_ff.close) |=>
         (acc_re_ff[0] == '0) && (acc_im_ff[0] == '0) && (acc_re_ff[1] == '0) &&
         (acc_im_ff[1] == '0) && (acc_re_ff[2] == '0) && (acc_im_ff[2] == '0))
      else $error("accumulators not cleared after emit");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      (!advance) |=>
         $stable(s1_valid_ff) && $stable(acc_re_ff[2]) && $stable(src_re_ff[0]))
      else $error("pipeline moved during output stall");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import acmv_pkg::*;

   localparam int RANDOM_TARGET  = 1450;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 12;
   localparam int MAX_REPORTS    = 10;

   localparam logic [VAL_W-1:0] MAX_VAL       = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] MIN_VAL       = 32'h8000_0000;
   localparam logic [VAL_W-1:0] ONE_VAL       = 32'h0100_0000;
   localparam logic [VAL_W-1:0] MINUS_ONE_VAL = 32'hFF00_0000;
   localparam logic signed [ACC_W-1:0] SAT_HI = 40'sh00_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_LO = 40'shFF_8000_0000;

   typedef struct packed {
      logic     drain;
      item_type body;
   } staged_req_type;

   typedef struct packed {
      logic [1:0]                      direction;
      logic [VEC_LEN-1:0][VAL_W-1:0]   re;
      logic [VEC_LEN-1:0][VAL_W-1:0]   im;
   } product_vec_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   staged_req_type  request_queue[$];
   product_vec_type pending_products[$];

   // predictor state: shared source vector and per-column accumulators
   logic signed [VAL_W-1:0] src_re [VEC_LEN];
   logic signed [VAL_W-1:0] src_im [VEC_LEN];
   logic signed [ACC_W-1:0] acc_re [VEC_LEN];
   logic signed [ACC_W-1:0] acc_im [VEC_LEN];

   logic req_hs = 1'b0;
   logic drain_next = 1'b0;
   int   useful_staged = 0;
   int   total_staged = 0;
   int   issued = 0;
   int   reqs_accepted = 0;
   int   reqs_ignored = 0;
   int   vectors_checked = 0;
   int   clipped = 0;
   int   mismatches = 0;
   int   idle_cycles = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;

   adjoint_complex_3x3_matvec dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // floor(a * b / 2^24), exact product first
   function automatic logic signed [ACC_W-1:0] fx_mul(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
      logic signed [PROD_W-1:0] p;
      p = a * b;
      return ACC_W'(p >>> FRAC_W);
   endfunction

   task automatic clip_into(input logic signed [ACC_W-1:0] v, output logic [VAL_W-1:0] q);
      if (v > SAT_HI) begin
         q = SAT_HI[VAL_W-1:0];
         clipped++;
      end else if (v < SAT_LO) begin
         q = SAT_LO[VAL_W-1:0];
         clipped++;
      end else begin
         q = v[VAL_W-1:0];
      end
   endtask

   task automatic adjoint_step(input item_type it, output logic emits,
                               output product_vec_type res);
      logic signed [VAL_W-1:0] br, bi;
      emits = 1'b0;
      res = '0;
      if (it.action == ACT_LOAD_SOURCE) begin
         if (it.row == INDEX_LIMIT) begin
            reqs_ignored++;
         end else begin
            src_re[it.row] = it.value_re;
            src_im[it.row] = it.value_im;
         end
      end else if (it.row == INDEX_LIMIT || it.col == INDEX_LIMIT
                   || int'(it.direction) >= NUM_DIRECTIONS) begin
         reqs_ignored++;
      end else begin
         br = src_re[it.row];
         bi = src_im[it.row];
         // conj(a) * b, each accumulator wraps at its width
         acc_re[it.col] = acc_re[it.col] + fx_mul(it.value_re, br) + fx_mul(it.value_im, bi);
         acc_im[it.col] = acc_im[it.col] + fx_mul(it.value_re, bi) - fx_mul(it.value_im, br);
         if (it.row == LAST_INDEX && it.col == LAST_INDEX) begin
            emits = 1'b1;
            res.direction = it.direction;
            for (int k = 0; k < VEC_LEN; k++) begin
               clip_into(acc_re[k], res.re[k]);
               clip_into(acc_im[k], res.im[k]);
               acc_re[k] = '0;
               acc_im[k] = '0;
            end
         end
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [VAL_W-1:0] want,
                                input logic [VAL_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch on %s at %0t ns: expected %h, got %h", field, $time, want, got);
      end
   endtask

   function automatic logic [VAL_W-1:0] rand_value();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(9))
         0: return MAX_VAL;
         1: return MIN_VAL;
         2, 3, 4: return r;
         default: return {{6{r[25]}}, r[25:0]};
      endcase
   endfunction

   task automatic stage(input action_type act, input logic [1:0] dir, input logic [1:0] row,
                        input logic [1:0] col, input logic [VAL_W-1:0] re,
                        input logic [VAL_W-1:0] im);
      staged_req_type s;
      s.drain = drain_next;
      s.body.action = act;
      s.body.direction = dir;
      s.body.row = row;
      s.body.col = col;
      s.body.value_re = re;
      s.body.value_im = im;
      drain_next = 1'b0;
      request_queue.push_back(s);
      if (row != INDEX_LIMIT && (act == ACT_LOAD_SOURCE || col != INDEX_LIMIT)) begin
         useful_staged++;
      end
   endtask

   task automatic stage_sources();
      int n;
      n = $urandom_range(3);
      repeat (n) begin
         stage(ACT_LOAD_SOURCE, 2'($urandom_range(3)), 2'($urandom_range(2)),
               2'($urandom_range(3)), rand_value(), rand_value());
      end
   endtask

   // row-major elements; stop early for an incomplete matrix, or scatter directions
   task automatic stage_matrix(input logic [1:0] dir, input int stop_after, input bit mix_dirs);
      for (int r = 0; r < VEC_LEN; r++) begin
         for (int c = 0; c < VEC_LEN; c++) begin
            if (r * VEC_LEN + c < stop_after) begin
               stage(ACT_ELEMENT, mix_dirs ? 2'($urandom_range(3)) : dir, 2'(r), 2'(c),
                     rand_value(), rand_value());
            end
         end
      end
   endtask

   initial begin
      int start;
      int pick;
      for (int k = 0; k < VEC_LEN; k++) begin
         src_re[k] = '0;
         src_im[k] = '0;
         acc_re[k] = '0;
         acc_im[k] = '0;
      end

      // directed: extremes, ignored indexes, wrap, shared accumulators, saturation
      stage(ACT_LOAD_SOURCE, 2'd0, 2'd0, 2'd0, MAX_VAL, MIN_VAL);
      stage(ACT_LOAD_SOURCE, 2'd1, 2'd1, 2'd3, MIN_VAL, MAX_VAL);
      stage(ACT_LOAD_SOURCE, 2'd2, 2'd2, 2'd1, ONE_VAL, MINUS_ONE_VAL);
      stage(ACT_LOAD_SOURCE, 2'd3, 2'd3, 2'd2, 32'h1234_5678, 32'h9ABC_DEF0);
      stage(ACT_ELEMENT, 2'd0, 2'd3, 2'd0, MAX_VAL, MAX_VAL);
      stage(ACT_ELEMENT, 2'd0, 2'd0, 2'd3, MIN_VAL, MIN_VAL);
      for (int r = 0; r < VEC_LEN; r++) begin
         for (int c = 0; c < VEC_LEN; c++) begin
            case (r)
               0: stage(ACT_ELEMENT, 2'd0, 2'(r), 2'(c), MIN_VAL, MAX_VAL);
               1: stage(ACT_ELEMENT, 2'd0, 2'(r), 2'(c), MAX_VAL, MIN_VAL);
               default: stage(ACT_ELEMENT, 2'd0, 2'(r), 2'(c), ONE_VAL, ONE_VAL);
            endcase
         end
      end
      stage(ACT_ELEMENT, 2'd1, 2'd0, 2'd0, MAX_VAL, MAX_VAL);
      stage(ACT_ELEMENT, 2'd1, 2'd1, 2'd1, MAX_VAL, MAX_VAL);
      stage(ACT_ELEMENT, 2'd2, 2'd2, 2'd2, ONE_VAL, MINUS_ONE_VAL);
      stage(ACT_LOAD_SOURCE, 2'd0, 2'd2, 2'd0, MAX_VAL, 32'h0);
      stage(ACT_ELEMENT, 2'd3, 2'd2, 2'd2, MAX_VAL, 32'h0);
      stage(ACT_ELEMENT, 2'd1, 2'd2, 2'd2, MIN_VAL, 32'h0);

      // hold the first random request until the directed results are all back
      drain_next = 1'b1;
      start = useful_staged;
      while (useful_staged - start < RANDOM_TARGET) begin
         if ($urandom_range(39) == 0) drain_next = 1'b1;
         pick = $urandom_range(99);
         if (pick < 70) begin
            stage_sources();
            stage_matrix(2'($urandom_range(3)), 9, 1'b0);
         end else if (pick < 80) begin
            stage_sources();
            stage_matrix(2'($urandom_range(3)), $urandom_range(1, 8), 1'b0);
         end else if (pick < 88) begin
            stage_matrix(2'd0, 9, 1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               stage(action_type'($urandom_range(1)), 2'($urandom_range(3)),
                     2'($urandom_range(3)), 2'($urandom_range(3)), rand_value(), rand_value());
            end
         end
      end
      total_staged = request_queue.size();

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      while (reqs_accepted < total_staged || pending_products.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d requests accepted, %0d of them ignored by the block; %0d product vectors checked",
               reqs_accepted, reqs_ignored, vectors_checked);
      $display("%0d output components saturated; %0d mismatches", clipped, mismatches);
      if (mismatches == 0) begin
         $display("adjoint_complex_3x3_matvec regression: pass");
      end else begin
         $display("adjoint_complex_3x3_matvec regression: fail");
      end
      $finish;
   end

   // request driver and result backpressure, both on the falling edge
   always @(negedge clock) begin : drive
      staged_req_type head;
      logic fire;
      if (issued * 3 < total_staged) begin
         send_idle_pct = 23;
         recv_idle_pct = 65;
      end else if (issued * 3 < total_staged * 2) begin
         send_idle_pct = 65;
         recv_idle_pct = 23;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_hs) begin
            fire = 1'b0;
            if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               // a drain request waits until every product vector has come back
               if (!request_queue[0].drain || pending_products.size() == 0) begin
                  head = request_queue.pop_front();
                  fire = 1'b1;
                  issued++;
                  req_tdata <= {2'b00, head.body.value_im, head.body.value_re,
                                head.body.col, head.body.row, head.body.direction};
                  req_tuser <= head.body.action;
               end
            end
            req_tvalid <= fire;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : observe
      item_type        it;
      product_vec_type want;
      product_vec_type got;
      product_vec_type res;
      logic            emits;
      if (reset) begin
         req_hs <= 1'b0;
      end else begin
         req_hs <= req_tvalid && req_tready;

         // check first so a response never pairs with a request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.direction = rsp_tdata[1:0];
            for (int k = 0; k < VEC_LEN; k++) begin
               got.re[k] = rsp_tdata[2 + 64 * k +: VAL_W];
               got.im[k] = rsp_tdata[34 + 64 * k +: VAL_W];
            end
            if (pending_products.size() == 0) begin
               flag_mismatch("unexpected result", '0, {30'b0, got.direction});
            end else begin
               want = pending_products.pop_front();
               vectors_checked++;
               if (got.direction != want.direction) begin
                  flag_mismatch("out_direction", {30'b0, want.direction}, {30'b0, got.direction});
               end
               for (int k = 0; k < VEC_LEN; k++) begin
                  if (got.re[k] != want.re[k]) begin
                     flag_mismatch($sformatf("res%0d_re", k), want.re[k], got.re[k]);
                  end
                  if (got.im[k] != want.im[k]) begin
                     flag_mismatch($sformatf("res%0d_im", k), want.im[k], got.im[k]);
                  end
               end
            end
         end

         if (req_tvalid && req_tready) begin
            it.action = action_type'(req_tuser);
            it.direction = req_tdata[1:0];
            it.row = req_tdata[3:2];
            it.col = req_tdata[5:4];
            it.value_re = req_tdata[37:6];
            it.value_im = req_tdata[69:38];
            adjoint_step(it, emits, res);
            if (emits) pending_products.push_back(res);
            reqs_accepted++;
         end

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("adjoint_complex_3x3_matvec regression: fail");
            $finish;
         end
      end
   end

endmodule
